// ----- src/spg_pkg.sv -----
// shared types, constants and helper functions for the sighting position geofence
`default_nettype none
package spg_pkg;

    localparam int ANG_W     = 27;
    localparam int XY_W      = 34;
    localparam int CORDIC_STEPS = 16;
    localparam int DIV_BITS  = 26;
    localparam int DIV_W     = 64;
    localparam int DEN_W     = 38;
    localparam int T_W       = 27;
    localparam int RECIP_W   = 26;
    localparam int RECIP_SHIFT = 31;

    localparam logic signed [ANG_W-1:0] ANG_FULL = 27'sd23592960;
    localparam logic signed [ANG_W-1:0] ANG_HALF = 27'sd11796480;
    localparam logic signed [ANG_W-1:0] ANG_QTR  = 27'sd5898240;
    localparam logic signed [XY_W-1:0]  CORDIC_GAIN = 34'sd652032874;

    localparam logic signed [23:0] LAT_LIM = 24'sd5898240;
    localparam logic signed [24:0] LON_LIM = 25'sd11796480;

    // ceil(2^31 / 60), exact floor division by 60 for values below 2^25
    localparam logic [RECIP_W-1:0] RECIP_60 = 26'd35791395;
    localparam logic [T_W-1:0]     HALF_60  = 27'd30;

    localparam logic [1:0] REG_LAT_MIN = 2'd0;
    localparam logic [1:0] REG_LAT_MAX = 2'd1;
    localparam logic [1:0] REG_LON_MIN = 2'd2;
    localparam logic [1:0] REG_LON_MAX = 2'd3;

    localparam logic signed [23:0] LAT_MIN_RST = 24'sd3407872;
    localparam logic signed [23:0] LAT_MAX_RST = 24'sd3462463;
    localparam logic signed [24:0] LON_MIN_RST = -25'sd327680;
    localparam logic signed [24:0] LON_MAX_RST = -25'sd262144;

    typedef struct packed {
        logic signed [XY_W-1:0]  x;
        logic signed [XY_W-1:0]  y;
        logic signed [ANG_W-1:0] z;
    } rot_t;

    typedef struct packed {
        logic signed [23:0] olat;
        logic signed [24:0] olon;
        logic [15:0]        rng;
        logic [7:0]         styp;
        logic [31:0]        user;
        logic               flip_b;
        logic               flip_l;
    } cpay_t;

    typedef struct packed {
        logic [DIV_W-1:0]    rem;
        logic [DEN_W-1:0]    den;
        logic [DIV_BITS-1:0] quo;
    } dv_t;

    typedef struct packed {
        logic signed [23:0] olat;
        logic signed [24:0] olon;
        logic [T_W-1:0]     t;
        logic               neg_lat;
        logic               neg_lon;
        logic               ovf;
        logic               zero;
        logic [7:0]         styp;
        logic [31:0]        user;
    } dpay_t;

    typedef struct packed {
        logic signed [ANG_W-1:0] ang;
        logic                    flip;
    } fold_t;

    // atan(2^-i) in degrees, 16 fraction bits
    function automatic logic signed [ANG_W-1:0] atan_q16(input int step);
        logic signed [ANG_W-1:0] r;
        begin
            case (step)
                0:  r = 27'sd2949120;
                1:  r = 27'sd1740967;
                2:  r = 27'sd919879;
                3:  r = 27'sd466945;
                4:  r = 27'sd234379;
                5:  r = 27'sd117305;
                6:  r = 27'sd58666;
                7:  r = 27'sd29335;
                8:  r = 27'sd14668;
                9:  r = 27'sd7334;
                10: r = 27'sd3667;
                11: r = 27'sd1833;
                12: r = 27'sd917;
                13: r = 27'sd458;
                14: r = 27'sd229;
                15: r = 27'sd115;
                default: r = '0;
            endcase
            return r;
        end
    endfunction

    // fold an angle in (-180, 180] into [-90, 90]; a fold negates sin and cos
    function automatic fold_t fold_angle(input logic signed [ANG_W-1:0] a);
        fold_t r;
        begin
            r.ang  = a;
            r.flip = 1'b0;
            if (a > ANG_QTR)
            begin
                r.ang  = a - ANG_HALF;
                r.flip = 1'b1;
            end
            else if (a < -ANG_QTR)
            begin
                r.ang  = a + ANG_HALF;
                r.flip = 1'b1;
            end
            return r;
        end
    endfunction

endpackage
`default_nettype wire

// ----- src/spg_cordic_cell.sv -----
// one rotation step for the bearing and latitude rotators
`default_nettype none
module spg_cordic_cell #(
    parameter int STEP = 0
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          en,
    input  logic          in_valid,
    input  spg_pkg::rot_t in_brg,
    input  spg_pkg::rot_t in_lat,
    input  spg_pkg::cpay_t in_pay,
    output logic          out_valid,
    output spg_pkg::rot_t out_brg,
    output spg_pkg::rot_t out_lat,
    output spg_pkg::cpay_t out_pay
);
    import spg_pkg::*;

    localparam logic signed [ANG_W-1:0] ATAN = atan_q16(STEP);

    function automatic rot_t rotate(input rot_t r);
        logic signed [XY_W-1:0] xs;
        logic signed [XY_W-1:0] ys;
        rot_t o;
        begin
            xs = r.x >>> STEP;
            ys = r.y >>> STEP;
            if (!r.z[ANG_W-1])
            begin
                o.x = r.x - ys;
                o.y = r.y + xs;
                o.z = r.z - ATAN;
            end
            else
            begin
                o.x = r.x + ys;
                o.y = r.y - xs;
                o.z = r.z + ATAN;
            end
            return o;
        end
    endfunction

    logic  valid_reg;
    rot_t  brg_reg;
    rot_t  brg_next;
    rot_t  lat_reg;
    rot_t  lat_next;
    cpay_t pay_reg;

    assign brg_next = rotate(in_brg);
    assign lat_next = rotate(in_lat);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else if (en)
            valid_reg <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            brg_reg <= brg_next;
            lat_reg <= lat_next;
            pay_reg <= in_pay;
        end
    end

    assign out_valid = valid_reg;
    assign out_brg   = brg_reg;
    assign out_lat   = lat_reg;
    assign out_pay   = pay_reg;

endmodule
`default_nettype wire

// ----- src/spg_div_cell.sv -----
// one quotient bit of the restoring divider
`default_nettype none
module spg_div_cell #(
    parameter int BIT = 0
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          en,
    input  logic          in_valid,
    input  spg_pkg::dv_t  in_dv,
    input  spg_pkg::dpay_t in_pay,
    output logic          out_valid,
    output spg_pkg::dv_t  out_dv,
    output spg_pkg::dpay_t out_pay
);
    import spg_pkg::*;

    logic             valid_reg;
    dv_t              dv_reg;
    dv_t              dv_next;
    dpay_t            pay_reg;
    logic [DIV_W-1:0] shifted;
    logic             ge;

    assign shifted = DIV_W'(in_dv.den) << BIT;
    assign ge      = in_dv.rem >= shifted;

    always_comb
    begin
        dv_next          = in_dv;
        dv_next.rem      = ge ? in_dv.rem - shifted : in_dv.rem;
        dv_next.quo[BIT] = ge;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else if (en)
            valid_reg <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            dv_reg  <= dv_next;
            pay_reg <= in_pay;
        end
    end

    assign out_valid = valid_reg;
    assign out_dv    = dv_reg;
    assign out_pay   = pay_reg;

endmodule
`default_nettype wire

// ----- src/sighting_position_geofence.sv -----
// Sighting position geofence: projects a target position from an observer
// position, bearing and range on a flat earth and flags it against a box.
// The block is a fully pipelined chain: one prep stage, 16 CORDIC cells
// computing sin/cos of bearing and observer latitude side by side, three
// multiply/normalize stages, 26 divider cells (one quotient bit each) for the
// longitude offset, and three finishing stages. It takes one beat per cycle
// unless stalled. The pipeline moves as a whole: it holds only while a result
// beat waits at the output under stall.
// Box bounds are exclusive and may be written only while the block is idle.
`default_nettype none
module sighting_position_geofence (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_stall,
    input  logic signed [23:0] observer_latitude,
    input  logic signed [24:0] observer_longitude,
    input  logic [24:0]        bearing,
    input  logic [15:0]        range_nmi,
    input  logic [7:0]         sighting_type,
    input  logic [31:0]        user_tag,
    output logic               out_valid,
    input  logic               out_stall,
    output logic signed [23:0] target_latitude,
    output logic signed [24:0] target_longitude,
    output logic               inside_box,
    output logic [7:0]         type_out,
    output logic [31:0]        user_out,
    input  logic               cfg_valid,
    output logic               cfg_ready,
    input  logic [1:0]         cfg_index,
    input  logic [24:0]        cfg_data
);
    import spg_pkg::*;

    localparam logic signed [25:0] LAT_HI = 26'(LAT_LIM);
    localparam logic signed [25:0] LAT_LO = -LAT_HI;
    localparam logic signed [27:0] LON_HI = 28'(LON_LIM);
    localparam logic signed [27:0] LON_LO = -LON_HI;

    logic en;

    // configuration
    logic signed [23:0] lat_min_reg;
    logic signed [23:0] lat_max_reg;
    logic signed [24:0] lon_min_reg;
    logic signed [24:0] lon_max_reg;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            lat_min_reg <= LAT_MIN_RST;
            lat_max_reg <= LAT_MAX_RST;
            lon_min_reg <= LON_MIN_RST;
            lon_max_reg <= LON_MAX_RST;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                REG_LAT_MIN: lat_min_reg <= $signed(cfg_data[23:0]);
                REG_LAT_MAX: lat_max_reg <= $signed(cfg_data[23:0]);
                REG_LON_MIN: lon_min_reg <= $signed(cfg_data);
                REG_LON_MAX: lon_max_reg <= $signed(cfg_data);
                default: ;
            endcase
        end
    end

    // the whole pipeline advances unless a result beat is held
    assign en       = !out_valid || !out_stall;
    assign in_stall = !en;

    // prep: reduce bearing to (-180, 180], fold both angles
    logic signed [ANG_W-1:0] brg_s;
    logic signed [ANG_W-1:0] brg_a1;
    logic signed [ANG_W-1:0] brg_a2;
    fold_t                   fold_b;
    fold_t                   fold_l;
    rot_t                    brg_rot [CORDIC_STEPS+1];
    rot_t                    lat_rot [CORDIC_STEPS+1];
    cpay_t                   c_pay [CORDIC_STEPS+1];
    logic                    c_v [CORDIC_STEPS+1];
    logic                    p_valid_reg;
    rot_t                    p_brg_reg;
    rot_t                    p_lat_reg;
    cpay_t                   p_pay_reg;
    rot_t                    p_brg_next;
    rot_t                    p_lat_next;
    cpay_t                   p_pay_next;

    always_comb
    begin
        brg_s  = $signed({2'b00, bearing});
        brg_a1 = (brg_s >= ANG_FULL) ? brg_s - ANG_FULL : brg_s;
        brg_a2 = (brg_a1 > ANG_HALF) ? brg_a1 - ANG_FULL : brg_a1;
        fold_b = fold_angle(brg_a2);
        fold_l = fold_angle(ANG_W'(observer_latitude));
        p_brg_next.x = CORDIC_GAIN;
        p_brg_next.y = '0;
        p_brg_next.z = fold_b.ang;
        p_lat_next.x = CORDIC_GAIN;
        p_lat_next.y = '0;
        p_lat_next.z = fold_l.ang;
        p_pay_next.olat   = observer_latitude;
        p_pay_next.olon   = observer_longitude;
        p_pay_next.rng    = range_nmi;
        p_pay_next.styp   = sighting_type;
        p_pay_next.user   = user_tag;
        p_pay_next.flip_b = fold_b.flip;
        p_pay_next.flip_l = fold_l.flip;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            p_valid_reg <= 1'b0;
        else if (en)
            p_valid_reg <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            p_brg_reg <= p_brg_next;
            p_lat_reg <= p_lat_next;
            p_pay_reg <= p_pay_next;
        end
    end

    assign c_v[0]     = p_valid_reg;
    assign brg_rot[0] = p_brg_reg;
    assign lat_rot[0] = p_lat_reg;
    assign c_pay[0]   = p_pay_reg;

    for (genvar i = 0; i < CORDIC_STEPS; i++)
    begin : g_cordic
        spg_cordic_cell #(.STEP(i)) u_cell (
            .clk       (clk),
            .rst_n     (rst_n),
            .en        (en),
            .in_valid  (c_v[i]),
            .in_brg    (brg_rot[i]),
            .in_lat    (lat_rot[i]),
            .in_pay    (c_pay[i]),
            .out_valid (c_v[i+1]),
            .out_brg   (brg_rot[i+1]),
            .out_lat   (lat_rot[i+1]),
            .out_pay   (c_pay[i+1])
        );
    end

    // multiply: range by cos/sin of bearing, cos of latitude by 60
    rot_t                   mb;
    rot_t                   ml;
    cpay_t                  mp;
    logic signed [XY_W-1:0] sb_w;
    logic signed [XY_W-1:0] cb_w;
    logic signed [XY_W-1:0] cl_w;
    logic signed [31:0]     sb;
    logic signed [31:0]     cb;
    logic signed [31:0]     cl;
    logic signed [16:0]     rng_s;
    logic                   m_valid_reg;
    logic signed [48:0]     m_lat_reg;
    logic signed [48:0]     m_lat_next;
    logic signed [48:0]     m_num_reg;
    logic signed [48:0]     m_num_next;
    logic signed [38:0]     m_den_reg;
    logic signed [38:0]     m_den_next;
    cpay_t                  m_pay_reg;

    always_comb
    begin
        mb    = brg_rot[CORDIC_STEPS];
        ml    = lat_rot[CORDIC_STEPS];
        mp    = c_pay[CORDIC_STEPS];
        sb_w  = mp.flip_b ? -mb.y : mb.y;
        cb_w  = mp.flip_b ? -mb.x : mb.x;
        cl_w  = mp.flip_l ? -ml.x : ml.x;
        sb    = $signed(sb_w[31:0]);
        cb    = $signed(cb_w[31:0]);
        cl    = $signed(cl_w[31:0]);
        rng_s = $signed({1'b0, mp.rng});
        m_lat_next = rng_s * cb;
        m_num_next = rng_s * sb;
        m_den_next = cl * 39'sd60;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            m_valid_reg <= 1'b0;
        else if (en)
            m_valid_reg <= c_v[CORDIC_STEPS];
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            m_lat_reg <= m_lat_next;
            m_num_reg <= m_num_next;
            m_den_reg <= m_den_next;
            m_pay_reg <= mp;
        end
    end

    // magnitudes and signs
    logic signed [48:0] abs_lat_s;
    logic signed [48:0] abs_num_s;
    logic signed [38:0] abs_den_s;
    logic               n1_valid_reg;
    logic [55:0]        n1_num_reg;
    logic [DEN_W-1:0]   n1_den_reg;
    dpay_t              n1_pay_reg;
    dpay_t              n1_pay_next;

    always_comb
    begin
        abs_lat_s = m_lat_reg[48] ? -m_lat_reg : m_lat_reg;
        abs_num_s = m_num_reg[48] ? -m_num_reg : m_num_reg;
        abs_den_s = m_den_reg[38] ? -m_den_reg : m_den_reg;
        n1_pay_next.olat    = m_pay_reg.olat;
        n1_pay_next.olon    = m_pay_reg.olon;
        // round half away: floor(|n| / 2^22) + 30, later divided by 60
        n1_pay_next.t       = T_W'(abs_lat_s[47:22]) + HALF_60;
        n1_pay_next.neg_lat = m_lat_reg[48];
        n1_pay_next.neg_lon = m_num_reg[48] ^ m_den_reg[38];
        n1_pay_next.ovf     = 1'b0;
        n1_pay_next.zero    = (m_num_reg == '0);
        n1_pay_next.styp    = m_pay_reg.styp;
        n1_pay_next.user    = m_pay_reg.user;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            n1_valid_reg <= 1'b0;
        else if (en)
            n1_valid_reg <= m_valid_reg;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            n1_num_reg <= {abs_num_s[47:0], 8'b0};
            n1_den_reg <= abs_den_s[DEN_W-1:0];
            n1_pay_reg <= n1_pay_next;
        end
    end

    // dividend with half divisor, overflow check against the quotient span
    dv_t              dv_s [DIV_BITS+1];
    dpay_t            dp_s [DIV_BITS+1];
    logic             dv_v [DIV_BITS+1];
    logic [DIV_W-1:0] n2_rem;
    logic             n2_valid_reg;
    dv_t              n2_dv_reg;
    dv_t              n2_dv_next;
    dpay_t            n2_pay_reg;
    dpay_t            n2_pay_next;

    always_comb
    begin
        n2_rem          = DIV_W'(n1_num_reg) + DIV_W'(n1_den_reg >> 1);
        n2_dv_next.rem  = n2_rem;
        n2_dv_next.den  = n1_den_reg;
        n2_dv_next.quo  = '0;
        n2_pay_next     = n1_pay_reg;
        n2_pay_next.ovf = n2_rem >= (DIV_W'(n1_den_reg) << DIV_BITS);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            n2_valid_reg <= 1'b0;
        else if (en)
            n2_valid_reg <= n1_valid_reg;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            n2_dv_reg  <= n2_dv_next;
            n2_pay_reg <= n2_pay_next;
        end
    end

    assign dv_v[0] = n2_valid_reg;
    assign dv_s[0] = n2_dv_reg;
    assign dp_s[0] = n2_pay_reg;

    for (genvar j = 0; j < DIV_BITS; j++)
    begin : g_div
        spg_div_cell #(.BIT(DIV_BITS-1-j)) u_cell (
            .clk       (clk),
            .rst_n     (rst_n),
            .en        (en),
            .in_valid  (dv_v[j]),
            .in_dv     (dv_s[j]),
            .in_pay    (dp_s[j]),
            .out_valid (dv_v[j+1]),
            .out_dv    (dv_s[j+1]),
            .out_pay   (dp_s[j+1])
        );
    end

    // offsets: latitude by reciprocal of 60, longitude from the quotient
    dpay_t                      fp;
    logic [T_W+RECIP_W-1:0]     lat_prod;
    logic [21:0]                lat_mag;
    logic [DIV_BITS-1:0]        q;
    logic                       f1_valid_reg;
    logic signed [22:0]         f1_dlat_reg;
    logic signed [22:0]         f1_dlat_next;
    logic signed [DIV_BITS:0]   f1_dlon_reg;
    logic signed [DIV_BITS:0]   f1_dlon_next;
    logic                       f1_ovf_reg;
    dpay_t                      f1_pay_reg;

    always_comb
    begin
        fp       = dp_s[DIV_BITS];
        q        = dv_s[DIV_BITS].quo;
        lat_prod = (T_W+RECIP_W)'(fp.t) * (T_W+RECIP_W)'(RECIP_60);
        lat_mag  = lat_prod[RECIP_SHIFT+21:RECIP_SHIFT];
        f1_dlat_next = fp.neg_lat ? -$signed({1'b0, lat_mag}) : $signed({1'b0, lat_mag});
        if (fp.zero)
            f1_dlon_next = '0;
        else
            f1_dlon_next = fp.neg_lon ? -$signed({1'b0, q}) : $signed({1'b0, q});
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            f1_valid_reg <= 1'b0;
        else if (en)
            f1_valid_reg <= dv_v[DIV_BITS];
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            f1_dlat_reg <= f1_dlat_next;
            f1_dlon_reg <= f1_dlon_next;
            f1_ovf_reg  <= fp.ovf && !fp.zero;
            f1_pay_reg  <= fp;
        end
    end

    // add and saturate
    logic signed [25:0] slat;
    logic signed [27:0] slon;
    logic signed [23:0] tlat_next;
    logic signed [24:0] tlon_next;
    logic               f2_valid_reg;
    logic signed [23:0] f2_lat_reg;
    logic signed [24:0] f2_lon_reg;
    logic [7:0]         f2_styp_reg;
    logic [31:0]        f2_user_reg;

    always_comb
    begin
        slat = 26'(f1_pay_reg.olat) + 26'(f1_dlat_reg);
        slon = 28'(f1_pay_reg.olon) + 28'(f1_dlon_reg);
        if (slat > LAT_HI)
            tlat_next = LAT_LIM;
        else if (slat < LAT_LO)
            tlat_next = -LAT_LIM;
        else
            tlat_next = slat[23:0];
        if (f1_ovf_reg)
            tlon_next = f1_pay_reg.neg_lon ? -LON_LIM : LON_LIM;
        else if (slon > LON_HI)
            tlon_next = LON_LIM;
        else if (slon < LON_LO)
            tlon_next = -LON_LIM;
        else
            tlon_next = slon[24:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            f2_valid_reg <= 1'b0;
        else if (en)
            f2_valid_reg <= f1_valid_reg;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            f2_lat_reg  <= tlat_next;
            f2_lon_reg  <= tlon_next;
            f2_styp_reg <= f1_pay_reg.styp;
            f2_user_reg <= f1_pay_reg.user;
        end
    end

    // box test and output beat
    logic               out_valid_reg;
    logic signed [23:0] out_lat_reg;
    logic signed [24:0] out_lon_reg;
    logic               inside_reg;
    logic               inside_next;
    logic [7:0]         type_reg;
    logic [31:0]        user_reg;

    assign inside_next = (lat_min_reg < f2_lat_reg) && (f2_lat_reg < lat_max_reg) &&
                         (lon_min_reg < f2_lon_reg) && (f2_lon_reg < lon_max_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (en)
            out_valid_reg <= f2_valid_reg;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            out_lat_reg <= f2_lat_reg;
            out_lon_reg <= f2_lon_reg;
            inside_reg  <= inside_next;
            type_reg    <= f2_styp_reg;
            user_reg    <= f2_user_reg;
        end
    end

    assign out_valid        = out_valid_reg;
    assign target_latitude  = out_lat_reg;
    assign target_longitude = out_lon_reg;
    assign inside_box       = inside_reg;
    assign type_out         = type_reg;
    assign user_out         = user_reg;

    a_lat_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (target_latitude <= LAT_LIM && target_latitude >= -LAT_LIM))
        else $error("target latitude outside saturation range");

    a_lon_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (target_longitude <= LON_LIM && target_longitude >= -LON_LIM))
        else $error("target longitude outside saturation range");

    a_inside: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && inside_box) |->
            (lat_min_reg < target_latitude && target_latitude < lat_max_reg &&
             lon_min_reg < target_longitude && target_longitude < lon_max_reg))
        else $error("inside flag set for a point outside the box");

    a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> (out_valid && out_stall))
        else $error("input stalled without a held output beat");

endmodule
`default_nettype wire

// ----- tb/sighting_position_geofence_tb.sv -----
// testbench for the sighting position geofence: fixed-point predictor, directed and random sightings
`default_nettype none
module sighting_position_geofence_tb;
    import spg_pkg::*;

    localparam longint FULL_TURN = 64'sd23592960;
    localparam longint HALF_TURN = 64'sd11796480;
    localparam longint QTR_TURN = 64'sd5898240;
    localparam longint LAT_SAT = 64'sd5898240;
    localparam longint LON_SAT = 64'sd11796480;
    localparam longint HUGE_OFFSET = 64'sd1 << 40;
    localparam int IDLE_LIMIT = 20000;
    localparam int DRAIN_CYCLES = 80;

    logic clk;
    logic rst_n;
    logic in_valid;
    logic in_stall;
    logic signed [23:0] observer_latitude;
    logic signed [24:0] observer_longitude;
    logic [24:0] bearing;
    logic [15:0] range_nmi;
    logic [7:0] sighting_type;
    logic [31:0] user_tag;
    logic out_valid;
    logic out_stall;
    logic signed [23:0] target_latitude;
    logic signed [24:0] target_longitude;
    logic inside_box;
    logic [7:0] type_out;
    logic [31:0] user_out;
    logic cfg_valid;
    logic cfg_ready;
    logic [1:0] cfg_index;
    logic [24:0] cfg_data;

    typedef struct packed {
        logic signed [23:0] lat;
        logic signed [24:0] lon;
        logic in_box;
        logic [7:0] typ;
        logic [31:0] user;
    } fix_t;

    fix_t pending_fixes[$];
    longint box_lat_min, box_lat_max, box_lon_min, box_lon_max;
    longint arctan_q16[16];
    int error_count;
    int sightings_sent;
    int fixes_checked;
    int idle_cycles;
    int inside_hits;
    bit stall_busy;
    bit stall_quiet;

    sighting_position_geofence dut (.*);

    always #5 clk = ~clk;

    function automatic longint shift_floor(longint v, int s);
        return v >>> s;
    endfunction

    function automatic longint div_half_away(longint n, longint d);
        bit neg;
        longint q;
        neg = 0;
        if (n < 0) begin n = -n; neg = !neg; end
        if (d < 0) begin d = -d; neg = !neg; end
        q = (n + d / 2) / d;
        return neg ? -q : q;
    endfunction

    function automatic longint saturate(longint v, longint lim);
        if (v > lim) return lim;
        if (v < -lim) return -lim;
        return v;
    endfunction

    // sine and cosine in Q30 by 16-step rotation, angle folded into [-90, 90]
    function automatic void rotate_q30(longint ang, output longint s, output longint c);
        longint a, x, y, nx;
        bit flip;
        a = ((ang % FULL_TURN) + FULL_TURN) % FULL_TURN;
        x = 64'sd652032874;
        y = 0;
        flip = 0;
        if (a > HALF_TURN) a -= FULL_TURN;
        if (a > QTR_TURN) begin a -= HALF_TURN; flip = 1; end
        else if (a < -QTR_TURN) begin a += HALF_TURN; flip = 1; end
        for (int i = 0; i < 16; i++)
        begin
            if (a >= 0)
            begin
                nx = x - shift_floor(y, i);
                y = y + shift_floor(x, i);
                a -= arctan_q16[i];
            end
            else
            begin
                nx = x + shift_floor(y, i);
                y = y - shift_floor(x, i);
                a += arctan_q16[i];
            end
            x = nx;
        end
        if (flip) begin x = -x; y = -y; end
        s = y;
        c = x;
    endfunction

    function automatic fix_t project_sighting(logic signed [23:0] olat_in,
        logic signed [24:0] olon_in, logic [24:0] brg_in, logic [15:0] rng_in,
        logic [7:0] typ, logic [31:0] user);
        longint olat, olon, rng, sb, cb, sl, cl, dlat, dlon, num, den, tlat, tlon;
        fix_t f;
        olat = olat_in;
        olon = olon_in;
        rng = rng_in;
        rotate_q30(longint'(brg_in), sb, cb);
        rotate_q30(olat, sl, cl);
        dlat = div_half_away(rng * cb, 64'sd60 << 22);
        num = rng * sb * 256;
        den = cl * 60;
        if (den == 0)
            dlon = (num > 0) ? HUGE_OFFSET : ((num < 0) ? -HUGE_OFFSET : 0);
        else
            dlon = div_half_away(num, den);
        tlat = saturate(olat + saturate(dlat, HUGE_OFFSET), LAT_SAT);
        tlon = saturate(olon + saturate(dlon, HUGE_OFFSET), LON_SAT);
        f.lat = tlat[23:0];
        f.lon = tlon[24:0];
        f.in_box = box_lat_min < tlat && tlat < box_lat_max
            && box_lon_min < tlon && tlon < box_lon_max;
        f.typ = typ;
        f.user = user;
        return f;
    endfunction

    task automatic report_mismatch(string what, longint got, longint want);
        $display("mismatch %s: got %0d expected %0d", what, got, want);
        error_count++;
    endtask

    // random gap, mostly short, now and then long
    function automatic int gap_length();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55) return 0;
        if (r < 92) return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    task automatic send_sighting(logic signed [23:0] lat, logic signed [24:0] lon,
        logic [24:0] brg, logic [15:0] rng, logic [7:0] typ, logic [31:0] user,
        bit paced);
        int g;
        g = paced ? gap_length() : 0;
        if (g > 0)
        begin
            in_valid <= 1'b0;
            repeat (g) @(posedge clk);
        end
        in_valid <= 1'b1;
        observer_latitude <= lat;
        observer_longitude <= lon;
        bearing <= brg;
        range_nmi <= rng;
        sighting_type <= typ;
        user_tag <= user;
        pending_fixes.push_back(project_sighting(lat, lon, brg, rng, typ, user));
        sightings_sent++;
        @(posedge clk);
        while (in_stall) @(posedge clk);
    endtask

    task automatic end_burst();
        in_valid <= 1'b0;
        @(posedge clk);
    endtask

    task automatic wait_drained();
        while (pending_fixes.size() != 0) @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic write_bound(logic [1:0] idx, longint value);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= value[24:0];
        @(posedge clk);
        while (!cfg_ready) @(posedge clk);
        cfg_valid <= 1'b0;
        case (idx)
            REG_LAT_MIN: box_lat_min = longint'($signed(value[23:0]));
            REG_LAT_MAX: box_lat_max = longint'($signed(value[23:0]));
            REG_LON_MIN: box_lon_min = longint'($signed(value[24:0]));
            default: box_lon_max = longint'($signed(value[24:0]));
        endcase
        @(posedge clk);
    endtask

    task automatic set_box(longint lat_lo, longint lat_hi, longint lon_lo, longint lon_hi);
        write_bound(REG_LAT_MIN, lat_lo);
        write_bound(REG_LAT_MAX, lat_hi);
        write_bound(REG_LON_MIN, lon_lo);
        write_bound(REG_LON_MAX, lon_hi);
    endtask

    function automatic longint rand_lat();
        return longint'($urandom_range(0, 11796480)) - LAT_SAT;
    endfunction

    function automatic longint rand_lon();
        return longint'($urandom_range(0, 23592960)) - LON_SAT;
    endfunction

    task automatic test_reset_box();
        // sightings near the default box so the flag gets hit both ways
        for (int i = 0; i < 12; i++)
            send_sighting(24'(24'sd3430000 + $urandom_range(0, 40000)),
                25'(-25'sd300000 + $urandom_range(0, 40000)),
                25'($urandom_range(0, 23592959)),
                16'($urandom_range(0, 3000)), 8'($urandom), $urandom, 1);
        end_burst();
        wait_drained();
    endtask

    task automatic test_directed();
        // field extremes, north/south poles where cos of latitude is zero
        send_sighting(24'sd5898240, 25'sd0, 25'd5898240, 16'hFFFF, 8'h00, 32'h0, 1);
        send_sighting(-24'sd5898240, 25'sd0, 25'd17694720, 16'hFFFF, 8'hFF, 32'hFFFFFFFF, 1);
        send_sighting(24'sd5898240, 25'sd0, 25'd0, 16'hFFFF, 8'h55, 32'h5555AAAA, 1);
        send_sighting(24'sd5898240, 25'sd100, 25'd0, 16'd0, 8'hAA, 32'hAAAA5555, 1);
        send_sighting(24'sd0, 25'sd11796480, 25'd5898240, 16'hFFFF, 8'd1, 32'd1, 1);
        send_sighting(24'sd0, -25'sd11796480, 25'd17694720, 16'hFFFF, 8'd2, 32'd2, 1);
        send_sighting(24'sd5898240, 25'sd11796480, 25'd0, 16'hFFFF, 8'd3, 32'd3, 1);
        send_sighting(-24'sd5898240, -25'sd11796480, 25'd11796480, 16'hFFFF, 8'd4, 32'd4, 1);
        // bearing at or past a full turn is reduced, max field value too
        send_sighting(24'sd100000, 25'sd0, 25'd23592959, 16'd5000, 8'd5, 32'd5, 1);
        send_sighting(24'sd100000, 25'sd0, 25'd23592960, 16'd5000, 8'd6, 32'd6, 1);
        send_sighting(24'sd100000, 25'sd0, 25'h1FFFFFF, 16'd5000, 8'd7, 32'd7, 1);
        // latitude past 90 degrees: negative cosine
        send_sighting(24'sh7FFFFF, 25'sh0FFFFFF, 25'd3000000, 16'd9000, 8'd8, 32'd8, 1);
        send_sighting(24'sh800000, 25'sh1000000, 25'd9000000, 16'd9000, 8'd9, 32'd9, 1);
        send_sighting(24'sd3440000, -25'sd290000, 25'd0, 16'd0, 8'd10, 32'd10, 1);
        send_sighting(24'sd0, 25'sd0, 25'd11796480, 16'd1, 8'd11, 32'd11, 1);
        end_burst();
        wait_drained();
    endtask

    task automatic test_random(int count, bit legal_only);
        longint lat, lon;
        for (int i = 0; i < count; i++)
        begin
            if (!legal_only && $urandom_range(0, 9) == 0)
            begin
                lat = longint'($signed(24'($urandom)));
                lon = longint'($signed(25'($urandom)));
            end
            else if ($urandom_range(0, 3) == 0)
            begin
                // aim close to the current box
                lat = saturate(box_lat_min + $urandom_range(0, 400000) - 100000, LAT_SAT);
                lon = saturate(box_lon_min + $urandom_range(0, 400000) - 100000, LON_SAT);
            end
            else
            begin
                lat = rand_lat();
                lon = rand_lon();
            end
            send_sighting(lat[23:0], lon[24:0],
                legal_only ? 25'($urandom_range(0, 23592959)) : 25'($urandom),
                ($urandom_range(0, 3) == 0) ? 16'($urandom) : 16'($urandom_range(0, 4000)),
                8'($urandom), $urandom, 1);
        end
        end_burst();
    endtask

    task automatic test_wide_box();
        set_box(-5898240, 5898240, -11796480, 11796480);
        test_random(300, 0);
        wait_drained();
    endtask

    task automatic test_random_boxes();
        longint a, b;
        for (int p = 0; p < 3; p++)
        begin
            a = rand_lat();
            b = rand_lat();
            set_box(a < b ? a : b, a < b ? b : a, -1000000 - $urandom_range(0, 5000000),
                1000000 + $urandom_range(0, 5000000));
            test_random(250, p != 1);
            wait_drained();
        end
        // inverted box never holds a point
        set_box(5898240, -5898240, 11796480, -11796480);
        test_random(120, 1);
        wait_drained();
    endtask

    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
        begin
            if (pending_fixes.size() == 0)
            begin
                $display("unexpected result beat");
                error_count++;
            end
            else
            begin
                fix_t w;
                w = pending_fixes.pop_front();
                if (target_latitude !== w.lat)
                    report_mismatch("target_latitude", target_latitude, w.lat);
                if (target_longitude !== w.lon)
                    report_mismatch("target_longitude", target_longitude, w.lon);
                if (inside_box !== w.in_box)
                    report_mismatch("inside_box", inside_box, w.in_box);
                if (type_out !== w.typ)
                    report_mismatch("type_out", type_out, w.typ);
                if (user_out !== w.user)
                    report_mismatch("user_out", user_out, w.user);
                inside_hits += w.in_box;
                fixes_checked++;
            end
        end
    end

    // receiver stalls, with quiet stretches and busy ones
    always @(posedge clk)
    begin
        if ($urandom_range(0, 199) == 0) stall_quiet <= !stall_quiet;
        if (stall_quiet)
            out_stall <= 1'b0;
        else if (stall_busy)
        begin
            out_stall <= 1'b1;
            if ($urandom_range(0, 9) == 0) stall_busy <= 0;
        end
        else
        begin
            out_stall <= ($urandom_range(0, 3) == 0);
            if ($urandom_range(0, 60) == 0) stall_busy <= 1;
        end
    end

    always @(posedge clk)
    begin
        if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= IDLE_LIMIT)
        begin
            $display("watchdog expired with %0d results outstanding", pending_fixes.size());
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    initial
    begin
        clk = 0;
        rst_n = 0;
        in_valid = 0;
        out_stall = 0;
        cfg_valid = 0;
        cfg_index = REG_LAT_MIN;
        cfg_data = '0;
        observer_latitude = '0;
        observer_longitude = '0;
        bearing = '0;
        range_nmi = '0;
        sighting_type = '0;
        user_tag = '0;
        stall_busy = 0;
        stall_quiet = 0;
        error_count = 0;
        sightings_sent = 0;
        fixes_checked = 0;
        idle_cycles = 0;
        inside_hits = 0;
        arctan_q16 = '{2949120, 1740967, 919879, 466945, 234379, 117305, 58666, 29335,
            14668, 7334, 3667, 1833, 917, 458, 229, 115};
        box_lat_min = 3407872;
        box_lat_max = 3462463;
        box_lon_min = -327680;
        box_lon_max = -262144;
        repeat (12) @(posedge clk);
        rst_n <= 1;
        @(posedge clk);
        test_reset_box();
        test_directed();
        test_wide_box();
        test_random_boxes();
        set_box(3407872, 3462463, -327680, -262144);
        test_random(60, 1);
        wait_drained();
        $display("%0d sightings sent, %0d results checked, %0d inside their box",
            sightings_sent, fixes_checked, inside_hits);
        $display("covered pole and over-range latitudes, bearing wrap, saturation, six boxes");
        if (error_count == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end
endmodule
`default_nettype wire
